>>> rtl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// Used by the front, back, top level and checker; no dependencies.
package bbc_pkg;

    // Default stack depth
    localparam int STACK_DEPTH_DEF = 64;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [7:0] CH_OPEN_ROUND  = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_NEWLINE      = 8'h0A;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_CLOSE_ROUND  = 3'd1;
    localparam logic [2:0] ST_CLOSE_SQUARE = 3'd2;
    localparam logic [2:0] ST_CLOSE_CURLY  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW     = 3'd4;

    // Bracket kind as held on the stack
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ROUND,
        KIND_SQUARE,
        KIND_CURLY
    } kind_t;

    // Classified operation
    typedef enum logic [1:0] {
        OP_PASS,
        OP_OPEN,
        OP_CLOSE,
        OP_NEWLINE
    } op_t;

    // Queue head as seen by the back
    typedef struct packed {
        logic  valid;
        op_t   op;
        kind_t kind;
    } cmd_t;

endpackage

>>> rtl/bbc_front.sv
// Front of the bracket balance checker: accepts characters, classifies
// them and holds them in a short queue for the back. Depends on bbc_pkg.
module bbc_front
    import bbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    output cmd_t       cmd,
    input  logic       cmd_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [1:0] op_mem [QUEUE_DEPTH];
    logic [1:0] kind_mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    op_t   cls_op;
    kind_t cls_kind;
    logic  push;
    logic  pop;

    // Classify the incoming character
    always_comb
    begin
        cls_op   = OP_PASS;
        cls_kind = KIND_NONE;
        case (char_in)
            CH_OPEN_ROUND:   begin cls_op = OP_OPEN;  cls_kind = KIND_ROUND;  end
            CH_OPEN_SQUARE:  begin cls_op = OP_OPEN;  cls_kind = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin cls_op = OP_OPEN;  cls_kind = KIND_CURLY;  end
            CH_CLOSE_ROUND:  begin cls_op = OP_CLOSE; cls_kind = KIND_ROUND;  end
            CH_CLOSE_SQUARE: begin cls_op = OP_CLOSE; cls_kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin cls_op = OP_CLOSE; cls_kind = KIND_CURLY;  end
            CH_NEWLINE:      cls_op = OP_NEWLINE;
            default:         cls_op = OP_PASS;
        endcase
    end

    // Stall when the queue is full
    assign in_stall = (fill_reg == NW'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign pop      = cmd_pop && (fill_reg != '0);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the classified transfer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]   <= cls_op;
            kind_mem[wr_ptr_reg] <= cls_kind;
        end
    end

    assign cmd.valid = (fill_reg != '0);
    assign cmd.op    = op_t'(op_mem[rd_ptr_reg]);
    assign cmd.kind  = kind_t'(kind_mem[rd_ptr_reg]);

endmodule

>>> rtl/bbc_back.sv
// Back of the bracket balance checker: runs the bracket stack and drives
// the result register. Depends on bbc_pkg.
module bbc_back
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic       line_end,
    output logic       unclosed_open,
    output logic [6:0] nesting_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Stack body; top and second entries are cached in flops
    kind_t stack_mem [STACK_DEPTH];

    logic [CW-1:0] count_reg, count_next;
    logic          halted_reg, halted_next;
    kind_t         top_reg;
    kind_t         sec_reg;
    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic          line_end_reg;
    logic          unclosed_reg;
    logic [6:0]    depth_reg;

    logic          fire;
    logic          do_push;
    logic          do_pop;
    logic [2:0]    st_val;
    logic          le_val;
    logic          unc_val;
    logic [2:0]    close_status;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // Take one command when the result register can take a result
    assign fire    = cmd.valid && (!out_valid_reg || !out_stall);
    assign cmd_pop = fire;

    // Error status for a closing bracket of each kind
    always_comb
    begin
        case (cmd.kind)
            KIND_ROUND:  close_status = ST_CLOSE_ROUND;
            KIND_SQUARE: close_status = ST_CLOSE_SQUARE;
            KIND_CURLY:  close_status = ST_CLOSE_CURLY;
            default:     close_status = ST_OK;
        endcase
    end

    // Execute the command against the stack
    always_comb
    begin
        st_val      = ST_OK;
        le_val      = 1'b0;
        unc_val     = 1'b0;
        count_next  = count_reg;
        halted_next = halted_reg;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        case (cmd.op)
            OP_NEWLINE:
            begin
                le_val      = 1'b1;
                unc_val     = (count_reg != '0);
                count_next  = '0;
                halted_next = 1'b0;
            end
            OP_OPEN:
            begin
                if (!halted_reg)
                begin
                    if (count_reg >= CW'(STACK_DEPTH))
                    begin
                        st_val      = ST_OVERFLOW;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        do_push    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            OP_CLOSE:
            begin
                if (!halted_reg)
                begin
                    if ((count_reg != '0) && (top_reg == cmd.kind))
                    begin
                        do_pop     = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        st_val      = close_status;
                        halted_next = 1'b1;
                    end
                end
            end
            default:
            begin
                st_val = ST_OK;
            end
        endcase
    end

    assign wr_addr = count_reg[AW-1:0];
    assign rd_addr = AW'(count_reg - CW'(3));

    // Hold stack control state and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg  <= count_next;
                halted_reg <= halted_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Write pushed kinds into the stack body
    always_ff @(posedge clk)
    begin
        if (fire && do_push)
        begin
            stack_mem[wr_addr] <= cmd.kind;
        end
    end

    // Refresh the cached top and second entries
    always_ff @(posedge clk)
    begin
        if (fire && do_push)
        begin
            top_reg <= cmd.kind;
            sec_reg <= top_reg;
        end
        else if (fire && do_pop)
        begin
            top_reg <= sec_reg;
            sec_reg <= stack_mem[rd_addr];
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= st_val;
            line_end_reg <= le_val;
            unclosed_reg <= unc_val;
            depth_reg    <= 7'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign line_end      = line_end_reg;
    assign unclosed_open = unclosed_reg;
    assign nesting_depth = depth_reg;

endmodule

>>> rtl/bracket_balance_checker.sv
// Top level of the bracket balance checker: front classifier and queue
// feeding the stack back end. Depends on bbc_pkg, bbc_front, bbc_back.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid, in_stall  | char_in[7:0]
//   out     | out_valid, out_stall| status[2:0], line_end, unclosed_open,
//           |                     | nesting_depth[6:0]
//
// One character per cycle sustained while out_stall is low. A character
// enters the queue when it transfers and takes its stack step when the back
// pops it, which loads the result register; the result is held there until
// it transfers. The stack step is a single compare of the cached top with a
// push or pop, with the next-below entry prefetched from the stack memory.
// Reset clears the queue, the stack count, the line halt and the result
// valid; no clearing pass is needed. An output stall fills the two-entry
// queue, after which in_stall rises.
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic       line_end,
    output logic       unclosed_open,
    output logic [6:0] nesting_depth
);

    cmd_t cmd;
    logic cmd_pop;

    // Accept and classify
    bbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .char_in  (char_in),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop)
    );

    // Execute against the stack
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .line_end      (line_end),
        .unclosed_open (unclosed_open),
        .nesting_depth (nesting_depth)
    );

endmodule

>>> rtl/bbc_checker.sv
// Port-level checks for the bracket balance checker, bound to its top level.
// Depends on bbc_pkg and bracket_balance_checker.
module bbc_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] char_in,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] status,
    input logic       line_end,
    input logic       unclosed_open,
    input logic [6:0] nesting_depth
);

    // A line end reports a clean status and an emptied stack
    a_line_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> (status == ST_OK) && (nesting_depth == '0))
        else $error("line end with error status or nonzero depth");

    // Unclosed flag only appears on a line end
    a_unclosed_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unclosed_open |-> line_end)
        else $error("unclosed flag outside line end");

    // Overflow is reported only with the stack full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OVERFLOW) |-> (nesting_depth == 7'(STACK_DEPTH)))
        else $error("overflow reported with stack not full");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(nesting_depth) && $stable(line_end))
        else $error("stalled result changed");

    // A stalled input transfer holds its character
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(char_in))
        else $error("stalled input changed");

endmodule

bind bracket_balance_checker bbc_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_bbc_checker (.*);

>>> test/bracket_balance_checker_tb.sv
// Testbench for bracket_balance_checker: drives character streams with random
// bursts and output stalls, and checks every result against a nesting tracker.
// Depends on bbc_pkg and the bracket_balance_checker RTL.
`timescale 1ns / 100ps

module bracket_balance_checker_tb
    import bbc_pkg::*;
;

    localparam int DEPTH = STACK_DEPTH_DEF;

    typedef struct {
        logic [2:0] status;
        logic       line_end;
        logic       unclosed;
        logic [6:0] depth;
    } verdict_t;

    typedef enum logic [1:0] {
        LINE_CLEAN,
        LINE_BROKEN,
        LINE_NOISE
    } line_style_t;

    // Tracks bracket nesting per line and holds the verdicts still to arrive
    class nesting_tracker;
        kind_t       held_kinds[DEPTH];
        int unsigned open_count;
        bit          halted;
        verdict_t    pending_verdicts[$];
        int unsigned mismatch_count;

        function new();
            open_count     = 0;
            halted         = 1'b0;
            mismatch_count = 0;
        endfunction

        // Work out the verdict for one transferred character
        function void take_char(logic [7:0] c);
            verdict_t v;
            kind_t    opener;
            kind_t    closer;
            v.status   = ST_OK;
            v.line_end = 1'b0;
            v.unclosed = 1'b0;
            opener     = KIND_NONE;
            closer     = KIND_NONE;
            case (c)
                CH_OPEN_ROUND:   opener = KIND_ROUND;
                CH_OPEN_SQUARE:  opener = KIND_SQUARE;
                CH_OPEN_CURLY:   opener = KIND_CURLY;
                CH_CLOSE_ROUND:  closer = KIND_ROUND;
                CH_CLOSE_SQUARE: closer = KIND_SQUARE;
                CH_CLOSE_CURLY:  closer = KIND_CURLY;
                default: ;
            endcase
            if (c == CH_NEWLINE)
            begin
                // report leftovers, then clear for the next line
                v.line_end = 1'b1;
                v.unclosed = (open_count != 0);
                open_count = 0;
                halted     = 1'b0;
            end
            else if (!halted)
            begin
                if (opener != KIND_NONE)
                begin
                    if (open_count >= DEPTH)
                    begin
                        v.status = ST_OVERFLOW;
                        halted   = 1'b1;
                    end
                    else
                    begin
                        held_kinds[open_count] = opener;
                        open_count++;
                    end
                end
                else if (closer != KIND_NONE)
                begin
                    if (open_count != 0 && held_kinds[open_count - 1] == closer)
                    begin
                        open_count--;
                    end
                    else
                    begin
                        case (closer)
                            KIND_ROUND:  v.status = ST_CLOSE_ROUND;
                            KIND_SQUARE: v.status = ST_CLOSE_SQUARE;
                            default:     v.status = ST_CLOSE_CURLY;
                        endcase
                        halted = 1'b1;
                    end
                end
            end
            v.depth = 7'(open_count);
            pending_verdicts.push_back(v);
        endfunction

        // Compare one result transfer with the oldest verdict
        function void match_result(logic [2:0] st, logic le, logic uo, logic [6:0] nd);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d line_end %0d unclosed %0d depth %0d",
                             st, le, uo, nd);
                return;
            end
            v = pending_verdicts.pop_front();
            if (st !== v.status || le !== v.line_end || uo !== v.unclosed || nd !== v.depth)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $write("mismatch: expected status %0d line_end %0d unclosed %0d depth %0d,",
                           v.status, v.line_end, v.unclosed, v.depth);
                    $display(" got status %0d line_end %0d unclosed %0d depth %0d",
                             st, le, uo, nd);
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic       line_end;
    logic       unclosed_open;
    logic [6:0] nesting_depth;

    nesting_tracker tracker;
    int             burst_left;
    int             chars_sent;
    bit             hold_request;

    bracket_balance_checker #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_in       (char_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .line_end      (line_end),
        .unclosed_open (unclosed_open),
        .nesting_depth (nesting_depth)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] opener_of(kind_t k);
        case (k)
            KIND_ROUND:  return CH_OPEN_ROUND;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            default:     return CH_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(kind_t k);
        case (k)
            KIND_ROUND:  return CH_CLOSE_ROUND;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            default:     return CH_CLOSE_CURLY;
        endcase
    endfunction

    // Offer one character, idling between bursts, and wait for its transfer
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_char(c);
        burst_left--;
        chars_sent++;
    endtask

    // Hold the input idle until every verdict has been matched
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    endtask

    // Build a line that mostly nests, with content shaped by its style
    task automatic emit_line(input line_style_t style, input int length, input int cap);
        kind_t      open_kinds[$];
        kind_t      k;
        logic [7:0] filler;
        int         r;
        for (int i = 0; i < length; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40 && open_kinds.size() < cap)
            begin
                k = kind_t'($urandom_range(1, 3));
                open_kinds.push_back(k);
                send_char(opener_of(k));
            end
            else if (r < 75 && open_kinds.size() > 0)
            begin
                k = open_kinds.pop_back();
                if (style == LINE_BROKEN && $urandom_range(0, 7) == 0)
                    k = kind_t'((int'(k) % 3) + 1);
                send_char(closer_of(k));
            end
            else if (r < 75 && style == LINE_BROKEN)
            begin
                send_char(closer_of(kind_t'($urandom_range(1, 3))));
            end
            else if (style == LINE_NOISE)
            begin
                send_char(8'($urandom_range(0, 255)));
            end
            else
            begin
                do filler = 8'($urandom_range(0, 255));
                while (filler == CH_NEWLINE || filler == CH_OPEN_ROUND ||
                       filler == CH_OPEN_SQUARE || filler == CH_OPEN_CURLY ||
                       filler == CH_CLOSE_ROUND || filler == CH_CLOSE_SQUARE ||
                       filler == CH_CLOSE_CURLY);
                send_char(filler);
            end
        end
        if ($urandom_range(0, 4) != 0)
            while (open_kinds.size() > 0) send_char(closer_of(open_kinds.pop_back()));
        send_char(CH_NEWLINE);
    endtask

    // Nest deep, then unwind some of it; pushes past the stack size overflow
    task automatic emit_deep(input int opens, input int closes);
        kind_t open_kinds[$];
        kind_t k;
        repeat (opens)
        begin
            k = kind_t'($urandom_range(1, 3));
            open_kinds.push_back(k);
            send_char(opener_of(k));
        end
        while (closes > 0 && open_kinds.size() > 0)
        begin
            send_char(closer_of(open_kinds.pop_back()));
            closes--;
        end
        send_char(CH_NEWLINE);
    endtask

    // Stall the output on random spans, with a long hold on request
    initial
    begin
        int pct;
        int span_left;
        out_stall = 1'b0;
        span_left = 0;
        pct       = 0;
        forever
        begin
            @(posedge clk);
            if (span_left == 0)
            begin
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    pct          = 100;
                    span_left    = 80;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       pct = 0;
                        1:       pct = 20;
                        2:       pct = 50;
                        default: pct = 85;
                    endcase
                    span_left = $urandom_range(10, 60);
                end
            end
            out_stall <= ($urandom_range(0, 99) < pct);
            span_left--;
        end
    end

    // Check each result transfer
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            tracker.match_result(status, line_end, unclosed_open, nesting_depth);
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [7:0] directed_chars[$];
        int         line_no;
        int         r;
        int         waited;
        int         leftover;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_in      = 8'h00;
        burst_left   = 0;
        chars_sent   = 0;
        hold_request = 1'b0;
        tracker      = new();
        directed_chars = '{
            8'h00, 8'hFF,
            CH_OPEN_ROUND, CH_OPEN_SQUARE, CH_OPEN_CURLY,
            CH_CLOSE_CURLY, CH_CLOSE_SQUARE, CH_CLOSE_ROUND,
            CH_CLOSE_ROUND, CH_OPEN_ROUND, CH_CLOSE_SQUARE, CH_NEWLINE,
            CH_OPEN_ROUND, CH_OPEN_ROUND, CH_CLOSE_SQUARE, 8'h78, CH_NEWLINE,
            CH_CLOSE_CURLY, CH_NEWLINE, CH_NEWLINE
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every bracket, errors on empty and mismatched tops, halted lines
        foreach (directed_chars[i]) send_char(directed_chars[i]);
        drain_results();

        // fill the stack exactly, then overflow it
        emit_deep(DEPTH, DEPTH);
        emit_deep(DEPTH + 3, 3);

        line_no = 0;
        while (chars_sent < 1100)
        begin
            line_no++;
            if (line_no == 12 || line_no == 70)
                hold_request = 1'b1;
            if (line_no % 40 == 0)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 3)
                emit_deep($urandom_range(DEPTH - 4, DEPTH + 4), $urandom_range(0, DEPTH + 4));
            else if (r < 75)
                emit_line(LINE_CLEAN, ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                                   : $urandom_range(0, 12),
                          $urandom_range(1, 10));
            else if (r < 90)
                emit_line(LINE_BROKEN, $urandom_range(1, 20), $urandom_range(1, 8));
            else
                emit_line(LINE_NOISE, $urandom_range(1, 20), $urandom_range(1, 8));
        end
        in_valid <= 1'b0;

        // wait out the remaining results, then watch for strays
        waited = 0;
        while (tracker.pending_verdicts.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        leftover = tracker.pending_verdicts.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);
        if (tracker.mismatch_count == 0 && leftover == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
